@@ rtl/bti_pkg.sv @@
// Shared types, sizes and codes of the binary image thinning unit.
// Used by the RAM wrapper users, the cell chain and the top level.
`timescale 1ns / 1ps
package bti_pkg;

   localparam int MAX_ROWS    = 64;
   localparam int MAX_COLS    = 64;
   localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;
   localparam int ROW_W       = $clog2(MAX_ROWS);
   localparam int COL_W       = $clog2(MAX_COLS);
   localparam int ROW_CNT_W   = $clog2(MAX_ROWS + 1);
   localparam int COL_CNT_W   = $clog2(MAX_COLS + 1);
   localparam int ADDR_W      = 12;
   localparam int CFG_W       = 7;
   localparam int PASS_W      = 12;

   localparam logic [PASS_W-1:0] PASS_LIMIT = {PASS_W{1'b1}};

   localparam logic [1:0] FUNC_WRITE = 2'd0;
   localparam logic [1:0] FUNC_RUN   = 2'd1;
   localparam logic [1:0] FUNC_READ  = 2'd2;

   localparam logic CSR_ROW_COUNT = 1'b0;
   localparam logic CSR_COL_COUNT = 1'b1;

   localparam logic [1:0] DIR_NORTH = 2'd0;
   localparam logic [1:0] DIR_SOUTH = 2'd1;
   localparam logic [1:0] DIR_EAST  = 2'd2;
   localparam logic [1:0] DIR_WEST  = 2'd3;

   typedef struct packed {
      logic       shift;
      logic [1:0] dir;
      logic       row_en;
   } cell_ctrl_type;

endpackage

@@ rtl/bti_ram.sv @@
// Generic simple dual port RAM with bit write mask and registered read.
// No dependencies.
`timescale 1ns / 1ps
module bti_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_mask,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         for (int i = 0; i < WIDTH; i++) begin
            if (wr_mask[i]) begin
               mem[wr_addr][i] <= wr_data[i];
            end
         end
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/bti_cell.sv @@
// One column cell: holds the upper and center pixel of its column and decides removal.
// Depends on bti_pkg.
`timescale 1ns / 1ps
module bti_cell
   import bti_pkg::*;
(
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  logic          col_en,
   input  logic          lower_in,
   input  logic          left_upper,
   input  logic          left_center,
   input  logic          left_lower,
   input  logic          right_upper,
   input  logic          right_center,
   input  logic          right_lower,
   output logic          upper_out,
   output logic          center_out,
   output logic          clear_out
);

   logic upper_ff;
   logic center_ff;
   logic n1, n2, n3, n4, n5, n6, n7, n8;
   logic [3:0] sum;
   logic dir_pix;
   logic keep;

   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         upper_ff  <= center_ff;
         center_ff <= lower_in;
      end
   end

   always_comb begin
      n1 = right_upper;
      n2 = upper_ff;
      n3 = left_upper;
      n4 = left_center;
      n5 = left_lower;
      n6 = lower_in;
      n7 = right_lower;
      n8 = right_center;
      sum = 4'(n1) + 4'(n2) + 4'(n3) + 4'(n4) + 4'(n5) + 4'(n6) + 4'(n7) + 4'(n8);
      case (ctrl.dir)
         DIR_NORTH: dir_pix = n2;
         DIR_SOUTH: dir_pix = n6;
         DIR_EAST:  dir_pix = n8;
         default:   dir_pix = n4;
      endcase
      keep = (n2 && !n4 && !n8 && (n5 || n6 || n7))
          || (n6 && !n4 && !n8 && (n1 || n2 || n3))
          || (n8 && !n2 && !n6 && (n3 || n4 || n5))
          || (n4 && !n2 && !n6 && (n7 || n8 || n1))
          || (n5 && !n4 && !n6)
          || (n7 && !n6 && !n8)
          || (n1 && !n8 && !n2)
          || (n3 && !n2 && !n4);
      clear_out = ctrl.row_en && col_en && center_ff && !dir_pix && (sum > 4'd1) && !keep;
   end

   assign upper_out  = upper_ff;
   assign center_out = center_ff;

endmodule

@@ rtl/bti_chain.sv @@
// Row of column cells that thins one image row per cycle while shift is set, from a three row window.
// Depends on bti_pkg and bti_cell.
`timescale 1ns / 1ps
module bti_chain
   import bti_pkg::*;
(
   input  logic                 clock,
   input  cell_ctrl_type        ctrl,
   input  logic [COL_CNT_W-1:0] cols_eff,
   input  logic [MAX_COLS-1:0]  lower_row,
   output logic [MAX_COLS-1:0]  row_out,
   output logic                 any_clear
);

   logic [MAX_COLS-1:0] upper_bits;
   logic [MAX_COLS-1:0] center_bits;
   logic [MAX_COLS-1:0] clear_bits;

   for (genvar c = 0; c < MAX_COLS; c++) begin : g_cell
      logic col_en;
      logic lu, lc, ll, ru, rc, rl;

      assign col_en = (c >= 1) && (32'(c) + 32'd2 <= 32'(cols_eff));

      if (c == 0) begin : g_left_edge
         assign lu = 1'b0;
         assign lc = 1'b0;
         assign ll = 1'b0;
      end else begin : g_left
         assign lu = upper_bits[c-1];
         assign lc = center_bits[c-1];
         assign ll = lower_row[c-1];
      end

      if (c == MAX_COLS - 1) begin : g_right_edge
         assign ru = 1'b0;
         assign rc = 1'b0;
         assign rl = 1'b0;
      end else begin : g_right
         assign ru = upper_bits[c+1];
         assign rc = center_bits[c+1];
         assign rl = lower_row[c+1];
      end

      bti_cell u_cell (
         .clock        (clock),
         .ctrl         (ctrl),
         .col_en       (col_en),
         .lower_in     (lower_row[c]),
         .left_upper   (lu),
         .left_center  (lc),
         .left_lower   (ll),
         .right_upper  (ru),
         .right_center (rc),
         .right_lower  (rl),
         .upper_out    (upper_bits[c]),
         .center_out   (center_bits[c]),
         .clear_out    (clear_bits[c])
      );
   end

   assign row_out   = center_bits & ~clear_bits;
   assign any_clear = |clear_bits;

endmodule

@@ rtl/binary_image_thinning_unit.sv @@
// Binary image thinning unit: image RAM of row words, a chain of column cells and control.
// Depends on bti_pkg, bti_ram and bti_chain.
//
// Pixel write and read requests stream at one per cycle unless the response is stalled;
// each passes a request register and then a response register. A run request thins the
// stored image: each sub-pass streams the image rows through the chain of column cells,
// one RAM row read per cycle with the thinned rows written back behind, and a run repeats
// the pass until one clears no pixel. No request is taken while a run is in progress.
`timescale 1ns / 1ps
module binary_image_thinning_unit
   import bti_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_func,
   input  logic [ADDR_W-1:0] req_pixel_address,
   input  logic              req_pixel_in,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_pixel_out,
   output logic [PASS_W-1:0] rsp_pass_count,
   input  logic              csr_wr_en,
   input  logic              csr_index,
   input  logic [CFG_W-1:0]  csr_wr_data
);

   typedef enum logic [1:0] {S_IDLE, S_DRAIN, S_SWEEP, S_DONE} state_type;

   state_type            state_ff;
   logic [ROW_CNT_W-1:0] cnt_ff;
   logic [1:0]           dir_ff;
   logic [PASS_W-1:0]    passes_ff;
   logic                 cleared_ff;
   logic                 p1_valid_ff;
   logic                 p1_read_ff;
   logic [ROW_W-1:0]     p1_row_ff;
   logic [COL_W-1:0]     p1_col_ff;
   logic                 out_valid_ff;
   logic                 out_pixel_ff;
   logic [PASS_W-1:0]    out_pass_ff;
   logic [CFG_W-1:0]     row_count_ff;
   logic [CFG_W-1:0]     col_count_ff;

   logic [ROW_CNT_W-1:0] rows_eff;
   logic [COL_CNT_W-1:0] cols_eff;
   logic                 accept;
   logic                 in_range;
   logic [ROW_W-1:0]     req_row;
   logic [COL_W-1:0]     req_col;
   logic                 p1_adv;
   logic                 done_load;
   logic                 sweeping;
   logic                 row_write;
   logic                 sweep_end;
   logic [PASS_W-1:0]    passes_in;
   cell_ctrl_type        ctrl;

   logic                 ram_wr_en;
   logic [ROW_W-1:0]     ram_wr_addr;
   logic [MAX_COLS-1:0]  ram_wr_mask;
   logic [MAX_COLS-1:0]  ram_wr_data;
   logic [ROW_W-1:0]     ram_rd_addr;
   logic [MAX_COLS-1:0]  ram_rd_data;
   logic [MAX_COLS-1:0]  chain_row;
   logic                 chain_clear;

   assign rows_eff = (32'(row_count_ff) > MAX_ROWS) ? ROW_CNT_W'(MAX_ROWS)
                                                    : ROW_CNT_W'(row_count_ff);
   assign cols_eff = (32'(col_count_ff) > MAX_COLS) ? COL_CNT_W'(MAX_COLS)
                                                    : COL_CNT_W'(col_count_ff);

   assign req_ready = (state_ff == S_IDLE) && (!p1_valid_ff || !out_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign in_range  = 32'(req_pixel_address) < STORE_DEPTH;
   assign req_row   = ROW_W'(req_pixel_address / MAX_COLS);
   assign req_col   = COL_W'(req_pixel_address % MAX_COLS);

   assign p1_adv    = p1_valid_ff && (!out_valid_ff || rsp_ready);
   assign done_load = (state_ff == S_DONE) && (!out_valid_ff || rsp_ready);

   assign sweeping  = (state_ff == S_SWEEP);
   assign row_write = sweeping && (cnt_ff >= ROW_CNT_W'(3)) && (cnt_ff <= rows_eff);
   assign sweep_end = sweeping && (cnt_ff == rows_eff);
   assign passes_in = (passes_ff == PASS_LIMIT) ? passes_ff : passes_ff + PASS_W'(1);

   assign ctrl.shift  = sweeping;
   assign ctrl.dir    = dir_ff;
   assign ctrl.row_en = row_write;

   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = req_row;
      ram_wr_mask = '0;
      ram_wr_data = {MAX_COLS{req_pixel_in}};
      if (sweeping) begin
         ram_wr_en   = row_write;
         ram_wr_addr = ROW_W'(cnt_ff - ROW_CNT_W'(2));
         ram_wr_mask = '1;
         ram_wr_data = chain_row;
      end else if (accept && (req_func == FUNC_WRITE) && in_range) begin
         ram_wr_en        = 1'b1;
         ram_wr_mask      = '0;
         ram_wr_mask[req_col] = 1'b1;
      end
      if (sweeping) begin
         ram_rd_addr = ROW_W'(cnt_ff);
      end else if (accept) begin
         ram_rd_addr = req_row;
      end else begin
         ram_rd_addr = p1_row_ff;
      end
   end

   bti_ram #(
      .WIDTH (MAX_COLS),
      .DEPTH (MAX_ROWS)
   ) u_image_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_mask (ram_wr_mask),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   bti_chain u_chain (
      .clock     (clock),
      .ctrl      (ctrl),
      .cols_eff  (cols_eff),
      .lower_row (ram_rd_data),
      .row_out   (chain_row),
      .any_clear (chain_clear)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         dir_ff       <= DIR_NORTH;
         passes_ff    <= '0;
         cleared_ff   <= 1'b0;
         p1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         row_count_ff <= CFG_W'(64);
         col_count_ff <= CFG_W'(64);
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_ROW_COUNT: row_count_ff <= csr_wr_data;
               CSR_COL_COUNT: col_count_ff <= csr_wr_data;
               default:       ;
            endcase
         end

         if (accept && (req_func != FUNC_RUN)) begin
            p1_valid_ff <= 1'b1;
         end else if (p1_adv) begin
            p1_valid_ff <= 1'b0;
         end

         if (p1_adv || done_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (accept && (req_func == FUNC_RUN)) begin
                  state_ff   <= S_DRAIN;
                  cnt_ff     <= '0;
                  dir_ff     <= DIR_NORTH;
                  passes_ff  <= '0;
                  cleared_ff <= 1'b0;
               end
            end
            S_DRAIN: begin
               if (!p1_valid_ff) begin
                  state_ff <= S_SWEEP;
               end
            end
            S_SWEEP: begin
               if (sweep_end) begin
                  cnt_ff <= '0;
                  if (dir_ff == DIR_WEST) begin
                     passes_ff  <= passes_in;
                     dir_ff     <= DIR_NORTH;
                     cleared_ff <= 1'b0;
                     if (!(cleared_ff || chain_clear)) begin
                        state_ff <= S_DONE;
                     end
                  end else begin
                     dir_ff <= dir_ff + 2'd1;
                     if (chain_clear) begin
                        cleared_ff <= 1'b1;
                     end
                  end
               end else begin
                  cnt_ff <= cnt_ff + ROW_CNT_W'(1);
                  if (chain_clear) begin
                     cleared_ff <= 1'b1;
                  end
               end
            end
            S_DONE: begin
               if (done_load) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         p1_read_ff <= (req_func == FUNC_READ) && in_range;
         p1_row_ff  <= req_row;
         p1_col_ff  <= req_col;
      end
      if (p1_adv) begin
         out_pixel_ff <= p1_read_ff && ram_rd_data[p1_col_ff];
         out_pass_ff  <= '0;
      end else if (done_load) begin
         out_pixel_ff <= 1'b0;
         out_pass_ff  <= passes_ff;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_pixel_out  = out_pixel_ff;
   assign rsp_pass_count = out_pass_ff;

`ifndef SYNTHESIS
   a_no_row_conflict: assert property (@(posedge clock) disable iff (reset)
      (sweeping && ram_wr_en) |-> (ram_wr_addr != ram_rd_addr))
      else $error("Row write collides with row read during a sweep.");

   a_sweep_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      sweeping |-> !p1_valid_ff)
      else $error("Pixel request in flight while sweeping.");

   a_run_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      done_load |-> (passes_ff != '0))
      else $error("Run response carries a zero pass count.");

   a_done_needs_quiet_pass: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SWEEP) ##1 (state_ff == S_DONE) |-> !$past(chain_clear))
      else $error("Run finished after a pass that cleared pixels.");
`endif

endmodule
